/* design/pru_pkg.sv */
// ----------------------------------------------------------------------------
// pru_pkg
// shared types, codes and limits of the pixel replication upscaler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pru_pkg;

    localparam int PRU_MAX_WIDTH = 2048;
    localparam int SCALE_W       = 7;
    localparam int COUNT_W       = 12;
    localparam int HEIGHT_W      = 16;
    localparam int PAD_W         = 2;
    localparam int COLOUR_W      = 8;
    localparam int PIXEL_W       = 3 * COLOUR_W;
    localparam int CFG_DATA_W    = 16;
    localparam int SCALE_LIMIT   = 100;
    localparam int PIXEL_BYTES   = 3;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_PIXEL   = 3'd1,
        ST_PAD     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_REFUSED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    // address bits for a store of the given depth, at least one
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

/* design/pru_if.sv */
// ----------------------------------------------------------------------------
// pru channel interfaces
// valid/ready channels for requests, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pru_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, op, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface pru_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
    logic       image_end;

    modport source (output valid, status, out_red, out_green, out_blue, row_end,
                    image_end, input ready);
    modport sink   (input valid, status, out_red, out_green, out_blue, row_end,
                    image_end, output ready);
endinterface

interface pru_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/pru_line_buf.sv */
// ----------------------------------------------------------------------------
// pru_line_buf
// single source row store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pru_line_buf
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = PRU_MAX_WIDTH
)
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [addr_bits(MAX_WIDTH)-1:0]   wr_addr,
    input  pixel_t                            wr_data,
    input  logic [addr_bits(MAX_WIDTH)-1:0]   rd_addr,
    output pixel_t                            rd_data
);

    pixel_t mem [MAX_WIDTH];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-through when the same entry is written and read
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pixel_replication_upscaler.sv */
// ----------------------------------------------------------------------------
// pixel_replication_upscaler
// the result is registered and valid in the cycle after its request transaction
// throughput: one request transaction per cycle, push or pull, while results drain
// the line store read is registered and always holds the current output column
// reset: counters and mode cleared, registers back to 1, line store not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_replication_upscaler
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = PRU_MAX_WIDTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    pru_req_if.sink   request,
    pru_res_if.source result,
    pru_cfg_if.sink   cfg
);

    localparam int AW     = addr_bits(MAX_WIDTH);
    // widest row that both the register field and the store can hold
    localparam int W_CLIP = (MAX_WIDTH > (2 ** COUNT_W) - 1) ? (2 ** COUNT_W) - 1 : MAX_WIDTH;

    // configuration registers
    logic [SCALE_W-1:0]  scale_reg;
    logic [COUNT_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // sequencing state
    logic [COUNT_W-1:0]  load_count_reg, load_count_next;
    logic                replaying_reg, replaying_next;
    logic [COUNT_W-1:0]  out_column_reg, out_column_next;
    logic [SCALE_W-1:0]  h_repeat_reg, h_repeat_next;
    logic [PAD_W-1:0]    pad_count_reg, pad_count_next;
    logic [SCALE_W-1:0]  v_repeat_reg, v_repeat_next;
    logic [HEIGHT_W-1:0] source_row_reg, source_row_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    pixel_t              pixel_reg, pixel_next;
    logic                row_end_reg, row_end_next;
    logic                image_end_reg, image_end_next;

    // effective settings
    logic [SCALE_W-1:0]  eff_scale;
    logic [COUNT_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic [PAD_W-1:0]    row_bytes_mod;
    logic [PAD_W-1:0]    pad_due;

    logic                accept;
    logic                done_row;
    logic                wr_en;
    pixel_t              rd_data;

    // a new request enters only while the output register is empty or its result is being taken
    assign accept        = request.valid && request.ready;
    assign request.ready = !out_valid_reg || result.ready;
    assign cfg.ready     = 1'b1;

    // saturate the registers into their working ranges
    always_comb
    begin
        if (scale_reg == '0)
        begin
            eff_scale = SCALE_W'(1);
        end
        else if (scale_reg > SCALE_W'(SCALE_LIMIT))
        begin
            eff_scale = SCALE_W'(SCALE_LIMIT);
        end
        else
        begin
            eff_scale = scale_reg;
        end

        if (width_reg == '0)
        begin
            eff_width = COUNT_W'(1);
        end
        else if (32'(width_reg) > W_CLIP)
        begin
            eff_width = COUNT_W'(W_CLIP);
        end
        else
        begin
            eff_width = width_reg;
        end

        eff_height = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    // bytes per output row mod 4 only needs the low bits of width and scale
    assign row_bytes_mod = PAD_W'(PAD_W'(eff_width[PAD_W-1:0] * eff_scale[PAD_W-1:0])
                                  * PAD_W'(PIXEL_BYTES));
    assign pad_due       = PAD_W'(PAD_W'(0) - row_bytes_mod);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= COUNT_W'(1);
            height_reg <= HEIGHT_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SCALE:  scale_reg  <= cfg.data[SCALE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg.data[COUNT_W-1:0];
                REG_HEIGHT: height_reg <= cfg.data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // one pass over the accepted request
    always_comb
    begin
        load_count_next = load_count_reg;
        replaying_next  = replaying_reg;
        out_column_next = out_column_reg;
        h_repeat_next   = h_repeat_reg;
        pad_count_next  = pad_count_reg;
        v_repeat_next   = v_repeat_reg;
        source_row_next = source_row_reg;
        status_next     = status_reg;
        pixel_next      = pixel_reg;
        row_end_next    = row_end_reg;
        image_end_next  = image_end_reg;
        done_row        = 1'b0;
        wr_en           = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_STORED;
            pixel_next     = '0;
            row_end_next   = 1'b0;
            image_end_next = 1'b0;

            if (op_t'(request.op) == OP_PUSH)
            begin
                if (replaying_reg)
                begin
                    status_next = ST_REFUSED;
                end
                else
                begin
                    wr_en           = (32'(load_count_reg) < MAX_WIDTH);
                    load_count_next = load_count_reg + COUNT_W'(1);
                    // last pixel of the row starts the replay
                    if (load_count_next >= eff_width)
                    begin
                        load_count_next = '0;
                        replaying_next  = 1'b1;
                        out_column_next = '0;
                        h_repeat_next   = '0;
                        pad_count_next  = '0;
                        v_repeat_next   = '0;
                    end
                end
            end
            else if (!replaying_reg)
            begin
                status_next = ST_EMPTY;
            end
            else if (out_column_reg < eff_width)
            begin
                status_next = ST_PIXEL;
                if (32'(out_column_reg) < MAX_WIDTH)
                begin
                    pixel_next = rd_data;
                end
                h_repeat_next = h_repeat_reg + SCALE_W'(1);
                if ((h_repeat_next >= eff_scale) || (h_repeat_next == '0))
                begin
                    h_repeat_next   = '0;
                    out_column_next = out_column_reg + COUNT_W'(1);
                end
                done_row = (out_column_next >= eff_width) && (pad_due == '0);
            end
            else
            begin
                // pad phase always gives at least one byte
                status_next    = ST_PAD;
                pad_count_next = pad_count_reg + PAD_W'(1);
                done_row       = (pad_count_next >= pad_due) || (pad_count_next == '0);
            end

            if (done_row)
            begin
                row_end_next    = 1'b1;
                out_column_next = '0;
                h_repeat_next   = '0;
                pad_count_next  = '0;
                v_repeat_next   = v_repeat_reg + SCALE_W'(1);
                // row replayed often enough: back to loading the next source row
                if (v_repeat_next >= eff_scale)
                begin
                    v_repeat_next   = '0;
                    replaying_next  = 1'b0;
                    load_count_next = '0;
                    source_row_next = source_row_reg + HEIGHT_W'(1);
                    if ((source_row_next >= eff_height) || (source_row_next == '0))
                    begin
                        source_row_next = '0;
                        image_end_next  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            replaying_reg  <= 1'b0;
            out_column_reg <= '0;
            h_repeat_reg   <= '0;
            pad_count_reg  <= '0;
            v_repeat_reg   <= '0;
            source_row_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            replaying_reg  <= replaying_next;
            out_column_reg <= out_column_next;
            h_repeat_reg   <= h_repeat_next;
            pad_count_reg  <= pad_count_next;
            v_repeat_reg   <= v_repeat_next;
            source_row_reg <= source_row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        pixel_reg     <= pixel_next;
        row_end_reg   <= row_end_next;
        image_end_reg <= image_end_next;
    end

    // read address follows the next output column, so the registered read
    // data is ready for the following pull
    pru_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(load_count_reg)),
        .wr_data ({request.in_red, request.in_green, request.in_blue}),
        .rd_addr (AW'(out_column_next)),
        .rd_data (rd_data)
    );

    assign result.valid     = out_valid_reg;
    assign result.status    = status_reg;
    assign result.out_red   = pixel_reg[3*COLOUR_W-1:2*COLOUR_W];
    assign result.out_green = pixel_reg[2*COLOUR_W-1:COLOUR_W];
    assign result.out_blue  = pixel_reg[COLOUR_W-1:0];
    assign result.row_end   = row_end_reg;
    assign result.image_end = image_end_reg;

endmodule

/* design/pru_checker.sv */
// ----------------------------------------------------------------------------
// pru_checker
// port-level checks on the pixel replication upscaler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pru_checker
    import pru_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] status,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic       row_end,
    input logic       image_end
);

    // a stalled result holds its status, row end, image end and red byte still
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            ($stable(status) && $stable(row_end) && $stable(image_end) && $stable(out_red)))
        else $error("stalled result changed");

    // a new result only follows a request transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && req_ready))
        else $error("result without request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && image_end) |-> row_end)
        else $error("image end off a row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && row_end) |-> (status == ST_PIXEL || status == ST_PAD))
        else $error("row end on a non-output status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status != ST_PIXEL) |->
            (out_red == '0 && out_green == '0 && out_blue == '0))
        else $error("colour bytes set on a non-pixel result");

endmodule

bind pixel_replication_upscaler pru_checker u_pru_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .status    (result.status),
    .out_red   (result.out_red),
    .out_green (result.out_green),
    .out_blue  (result.out_blue),
    .row_end   (result.row_end),
    .image_end (result.image_end)
);

/* verif/tb_pixel_replication_upscaler.sv */
// ----------------------------------------------------------------------------
// tb_pixel_replication_upscaler
// checks the pixel replication upscaler against a cycle-free shadow of its
// row loading, replay, padding and image counting, with random idling on the
// request and result channels and register writes between bursts of traffic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pixel_replication_upscaler;
    import pru_pkg::*;

    localparam int ROW_ALIGN    = 4;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_IDLE     = 16;

    // one expected output element
    typedef struct {
        status_t status;
        pixel_t  pix;
        bit      row_end;
        bit      image_end;
    } upscale_elem_t;

    // shadow copy of the upscaler: registers, line buffer and replay counters
    class replica_tracker;
        bit [SCALE_W-1:0]  scale_reg;
        bit [COUNT_W-1:0]  width_reg;
        bit [HEIGHT_W-1:0] height_reg;
        pixel_t            row_buf [PRU_MAX_WIDTH];
        int unsigned       filled;
        bit [COUNT_W-1:0]  load_idx;
        bit                replaying;
        bit [COUNT_W-1:0]  out_col;
        bit [SCALE_W-1:0]  h_rep;
        bit [PAD_W-1:0]    pad_cnt;
        bit [SCALE_W-1:0]  v_rep;
        bit [HEIGHT_W-1:0] src_row;
        upscale_elem_t     due_elements [$];
        int                errors;
        int                seen [5];
        int                rows;
        int                images;
        int                writes;

        function new();
            scale_reg  = 1;
            width_reg  = 1;
            height_reg = 1;
            foreach (row_buf[i])
                row_buf[i] = '0;
            filled    = 0;
            load_idx  = 0;
            replaying = 1'b0;
            out_col   = 0;
            h_rep     = 0;
            pad_cnt   = 0;
            v_rep     = 0;
            src_row   = 0;
            errors    = 0;
            foreach (seen[i])
                seen[i] = 0;
            rows   = 0;
            images = 0;
            writes = 0;
        endfunction

        function int unsigned eff_scale();
            if (scale_reg == 0)
                return 1;
            if (scale_reg > SCALE_LIMIT)
                return SCALE_LIMIT;
            return scale_reg;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > PRU_MAX_WIDTH)
                return PRU_MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function bit at_image_start();
            return !replaying && load_idx == 0 && src_row == 0;
        endfunction

        // true when the item changes state rather than being refused or empty
        function bit accepts(op_t op);
            return (op == OP_PUSH) ? !replaying : replaying;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SCALE:  scale_reg  = val[SCALE_W-1:0];
                REG_WIDTH:  width_reg  = val[COUNT_W-1:0];
                REG_HEIGHT: height_reg = val[HEIGHT_W-1:0];
                default: ;
            endcase
            writes++;
        endfunction

        // closes an output row, true when the whole image is done
        function bit close_row(int unsigned s);
            out_col = 0;
            h_rep   = 0;
            pad_cnt = 0;
            v_rep   = v_rep + 1'b1;
            if (v_rep < s)
                return 1'b0;
            v_rep     = 0;
            replaying = 1'b0;
            load_idx  = 0;
            src_row   = src_row + 1'b1;
            if (src_row >= eff_height() || src_row == 0)
            begin
                src_row = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void apply_request(op_t op, pixel_t pix);
            upscale_elem_t e;
            int unsigned   w;
            int unsigned   s;
            int unsigned   pad_len;
            bit            row_done;
            w           = eff_width();
            s           = eff_scale();
            row_done    = 1'b0;
            e.status    = ST_STORED;
            e.pix       = '0;
            e.row_end   = 1'b0;
            e.image_end = 1'b0;
            if (op == OP_PUSH)
            begin
                if (replaying)
                    e.status = ST_REFUSED;
                else
                begin
                    row_buf[load_idx] = pix;
                    if (load_idx + 1 > filled)
                        filled = load_idx + 1;
                    load_idx = load_idx + 1'b1;
                    if (load_idx >= w)
                    begin
                        load_idx  = 0;
                        replaying = 1'b1;
                        out_col   = 0;
                        h_rep     = 0;
                        pad_cnt   = 0;
                        v_rep     = 0;
                    end
                end
            end
            else if (!replaying)
                e.status = ST_EMPTY;
            else
            begin
                pad_len = (ROW_ALIGN - (w * s * PIXEL_BYTES) % ROW_ALIGN) % ROW_ALIGN;
                if (out_col < w)
                begin
                    e.status = ST_PIXEL;
                    e.pix    = row_buf[out_col];
                    h_rep    = h_rep + 1'b1;
                    if (h_rep >= s || h_rep == 0)
                    begin
                        h_rep   = 0;
                        out_col = out_col + 1'b1;
                    end
                    if (out_col >= w && pad_len == 0)
                        row_done = 1'b1;
                end
                else
                begin
                    e.status = ST_PAD;
                    pad_cnt  = pad_cnt + 1'b1;
                    if (pad_cnt >= pad_len || pad_cnt == 0)
                        row_done = 1'b1;
                end
                if (row_done)
                begin
                    e.row_end   = 1'b1;
                    e.image_end = close_row(s);
                end
            end
            due_elements.push_back(e);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(logic [2:0] status, logic [7:0] red, logic [7:0] green,
                                     logic [7:0] blue, logic row_end, logic image_end);
            upscale_elem_t e;
            if (due_elements.size() == 0)
            begin
                $error("result with nothing outstanding, status %0d", status);
                errors++;
                return;
            end
            e = due_elements.pop_front();
            check_field("status", 8'(e.status), 8'(status));
            check_field("out_red", e.pix[23:16], red);
            check_field("out_green", e.pix[15:8], green);
            check_field("out_blue", e.pix[7:0], blue);
            check_field("row_end", 8'(e.row_end), 8'(row_end));
            check_field("image_end", 8'(e.image_end), 8'(image_end));
            seen[e.status]++;
            if (e.row_end)
                rows++;
            if (e.image_end)
                images++;
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pru_req_if req_ch ();
    pru_res_if res_ch ();
    pru_cfg_if cfg_ch ();

    pixel_replication_upscaler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch),
        .cfg     (cfg_ch)
    );

    replica_tracker trk = new();

    // transactions left in a stretch with no idle cycles on either side
    int calm_items = 0;

    initial
    begin : clock_gen
        forever #6 clk = ~clk;
    end

    function automatic int draw_wait();
        return (calm_items > 0) ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic pixel_t draw_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    // one request transaction; called and returns on a falling edge, valid left high
    task automatic send_item(op_t op, pixel_t pix);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.in_red   <= pix[23:16];
        req_ch.in_green <= pix[15:8];
        req_ch.in_blue  <= pix[7:0];
        do
            @(posedge clk);
        while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        trk.apply_request(op, pix);
        if (calm_items > 0)
            calm_items--;
        @(negedge clk);
    endtask

    // drop valid and wait until every outstanding result has been taken
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (trk.due_elements.size() != 0)
            @(negedge clk);
    endtask

    // back-to-back register writes keep valid high; end_writes lowers it
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
        trk.set_register(idx, val);
        @(negedge clk);
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    // well-formed traffic until the block is back at the start of an image
    task automatic finish_image();
        do
            send_item(trk.replaying ? OP_PULL : OP_PUSH, draw_pixel());
        while (!trk.at_image_start());
    endtask

    // random register set, width kept within the loaded part of the line buffer during replay
    task automatic reconfigure();
        bit [2:0]              sel;
        logic [CFG_DATA_W-1:0] val;
        int unsigned           wv;
        drain();
        sel = $urandom_range(1, 7);
        if (sel[0])
        begin
            val = CFG_DATA_W'($urandom);
            val[SCALE_W-1:0] = ($urandom_range(0, 9) == 0) ? '0 : SCALE_W'($urandom_range(1, 5));
            write_reg(REG_SCALE, val);
        end
        if (sel[1])
        begin
            case ($urandom_range(0, 9))
                0:       wv = 0;
                1:       wv = $urandom_range(9, 40);
                default: wv = $urandom_range(1, 8);
            endcase
            // during replay a wider row would read entries never loaded
            if (trk.replaying && wv > trk.filled)
                wv = trk.filled;
            val = CFG_DATA_W'($urandom);
            val[COUNT_W-1:0] = COUNT_W'(wv);
            write_reg(REG_WIDTH, val);
        end
        if (sel[2])
        begin
            case ($urandom_range(0, 15))
                0:       val = '0;
                1:       val = '1;
                2:       val = CFG_DATA_W'($urandom);
                default: val = CFG_DATA_W'($urandom_range(1, 3));
            endcase
            write_reg(REG_HEIGHT, val);
        end
        end_writes();
    endtask

    // result side: random stalls, checks every accepted transaction
    initial
    begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
            trk.compare_result(res_ch.status, res_ch.out_red, res_ch.out_green,
                               res_ch.out_blue, res_ch.row_end, res_ch.image_end);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int counted;
        bit item_since_cfg;
        op_t op;
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_PUSH;
        req_ch.in_red   = '0;
        req_ch.in_green = '0;
        req_ch.in_blue  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_SCALE;
        cfg_ch.data     = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at reset: one pixel wide, one row, no enlargement
        send_item(OP_PULL, 24'h5A5A5A);     // nothing loaded yet
        send_item(OP_PUSH, 24'hFFFFFF);     // row complete, replay starts
        send_item(OP_PUSH, 24'h000000);     // push during replay is refused
        send_item(OP_PULL, 24'h000000);
        send_item(OP_PULL, 24'hFFFFFF);     // single pad byte closes row and image

        // scale of zero acts as one, height of zero acts as one
        drain();
        write_reg(REG_SCALE, 16'hFF80);
        write_reg(REG_WIDTH, 16'd8);
        write_reg(REG_HEIGHT, 16'd0);
        end_writes();
        send_item(OP_PUSH, 24'h000000);
        send_item(OP_PUSH, 24'hFFFFFF);
        send_item(OP_PUSH, 24'hFF0000);
        send_item(OP_PUSH, 24'h00FF00);
        send_item(OP_PUSH, 24'h0000FF);
        send_item(OP_PUSH, 24'hA5A5A5);
        send_item(OP_PUSH, 24'h5A5A5A);
        send_item(OP_PUSH, 24'h123456);
        repeat (5) send_item(OP_PULL, draw_pixel());

        // width lowered below the current column mid-row: with no pad due,
        // the next pull still gives one pad byte that ends the row
        drain();
        write_reg(REG_WIDTH, 16'd4);
        end_writes();
        send_item(OP_PULL, 24'hC3C3C3);

        // largest scale (saturated from the field maximum), one pixel wide:
        // the first output row ends on exactly the hundredth pull
        drain();
        write_reg(REG_SCALE, 16'h007F);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd1);
        end_writes();
        calm_items = 101;
        send_item(OP_PUSH, draw_pixel());
        repeat (100) send_item(OP_PULL, draw_pixel());

        // scale dropped back to one mid-image ends the replay after one more row
        drain();
        write_reg(REG_SCALE, 16'd1);
        end_writes();
        finish_image();

        // width field at its maximum: a long row keeps loading, then a
        // lowered width turns the next push into the start of the replay
        drain();
        write_reg(REG_WIDTH, 16'hFFFF);
        end_writes();
        calm_items = 24;
        repeat (24) send_item(OP_PUSH, draw_pixel());
        drain();
        write_reg(REG_WIDTH, 16'd16);
        end_writes();
        finish_image();
        calm_items = 0;

        // random traffic, mostly well-formed rows with noise and register
        // changes landing anywhere in an image
        reconfigure();
        counted        = 0;
        item_since_cfg = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (item_since_cfg && $urandom_range(0, 99) < 3)
            begin
                reconfigure();
                item_since_cfg = 1'b0;
            end
            else
            begin
                if (trk.replaying)
                    op = ($urandom_range(0, 99) < 92) ? OP_PULL : OP_PUSH;
                else
                    op = ($urandom_range(0, 99) < 88) ? OP_PUSH : OP_PULL;
                if (trk.accepts(op))
                    counted++;
                if (calm_items == 0 && $urandom_range(0, 99) < 2)
                    calm_items = $urandom_range(10, 60);
                send_item(op, draw_pixel());
                item_since_cfg = 1'b1;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("run covered %0d stored, %0d pixel, %0d pad, %0d empty, %0d refused transactions",
                 trk.seen[ST_STORED], trk.seen[ST_PIXEL], trk.seen[ST_PAD],
                 trk.seen[ST_EMPTY], trk.seen[ST_REFUSED]);
        $display("with %0d output rows, %0d whole images and %0d register writes",
                 trk.rows, trk.images, trk.writes);
        if (trk.errors == 0)
            $display("[pixel_replication_upscaler] OK");
        else
            $display("[pixel_replication_upscaler] ERROR");
        $finish;
    end

    // generous bound well above the slowest legal run
    initial
    begin : watchdog
        #(25_000_000);
        $display("timeout with %0d results outstanding", trk.due_elements.size());
        $display("[pixel_replication_upscaler] ERROR");
        $finish;
    end

endmodule
